// ===== src/sgwu_pkg.sv =====
// Shared types, codes and constant functions of the SOM weight update block.
// Depends on nothing; sgwu_div, sgwu_exp_rom and the top level import it.
`timescale 1ns / 1ps

package sgwu_pkg;

  // Command codes of the input transaction
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TRAIN = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LEARNING_RATE = 3'd0;
  localparam logic [2:0] CFG_INV_TWO_SIGMA = 3'd1;
  localparam logic [2:0] CFG_GRID_COLS     = 3'd2;
  localparam logic [2:0] CFG_NEURON_COUNT  = 3'd3;
  localparam logic [2:0] CFG_VECTOR_DIM    = 3'd4;
  localparam logic [2:0] CFG_UNIT_OFFSET   = 3'd5;

  // The exp table covers t in [0, 16) with t in Q4.8, i.e. 2^12 codes
  localparam int unsigned T_SPAN_LOG2 = 12;
  // Dividend width of the grid divider (winner and offset indexes)
  localparam int unsigned DIV_W       = 12;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W + 1);

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         neuron;
    logic [5:0]         element;
    logic signed [15:0] value;
    logic [11:0]        winner;
  } sgwu_in_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic               status;
  } sgwu_out_t;

  // Result of the shared grid divider
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [7:0]       rem;
  } div_res_t;

  // exp(-x) in Q32 from a 21-term Taylor series, each term truncated
  function automatic logic [63:0] taylor_base(logic [63:0] x);
    logic [63:0] term;
    logic [63:0] base;
    term = 64'h1_0000_0000;
    base = 64'h1_0000_0000;
    term = ((term * x) >> 32) / 1;  base = base - term;
    term = ((term * x) >> 32) / 2;  base = base + term;
    term = ((term * x) >> 32) / 3;  base = base - term;
    term = ((term * x) >> 32) / 4;  base = base + term;
    term = ((term * x) >> 32) / 5;  base = base - term;
    term = ((term * x) >> 32) / 6;  base = base + term;
    term = ((term * x) >> 32) / 7;  base = base - term;
    term = ((term * x) >> 32) / 8;  base = base + term;
    term = ((term * x) >> 32) / 9;  base = base - term;
    term = ((term * x) >> 32) / 10; base = base + term;
    term = ((term * x) >> 32) / 11; base = base - term;
    term = ((term * x) >> 32) / 12; base = base + term;
    term = ((term * x) >> 32) / 13; base = base - term;
    term = ((term * x) >> 32) / 14; base = base + term;
    term = ((term * x) >> 32) / 15; base = base - term;
    term = ((term * x) >> 32) / 16; base = base + term;
    term = ((term * x) >> 32) / 17; base = base - term;
    term = ((term * x) >> 32) / 18; base = base + term;
    term = ((term * x) >> 32) / 19; base = base - term;
    term = ((term * x) >> 32) / 20; base = base + term;
    return base;
  endfunction

  // Table entry k: base^k in Q32, truncated per product, rounded to Q1.16
  function automatic logic [16:0] exp_entry(logic [63:0] base, int k);
    logic [63:0] e;
    e = 64'h1_0000_0000;
    for (int j = 0; j < k; j++) begin
      e = (e * base) >> 32;
    end
    return 17'((e + 64'd32768) >> 16);
  endfunction

endpackage

// ===== src/sgwu_mul.sv =====
// Shared unsigned 33 x 17 multiplier used by every product of the update.
// Depends on nothing; the sequencer registers each product.
`timescale 1ns / 1ps

module sgwu_mul (
  input  logic [32:0] a_i,
  input  logic [16:0] b_i,
  output logic [49:0] p_o
);

  // Form the full product
  assign p_o = 50'(a_i) * 50'(b_i);

endmodule

// ===== src/sgwu_div.sv =====
// Restoring divider, one quotient bit per cycle, for grid row and column.
// Depends on sgwu_pkg for the result struct and widths.
`timescale 1ns / 1ps

module sgwu_div import sgwu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [7:0]       divisor_i,
  output div_res_t         res_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     num_q;
  logic [7:0]           rem_q;
  logic [7:0]           den_q;
  logic [8:0]           trial;
  logic                 fits;

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, num_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  // Control: count the steps, pulse done at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift quotient bits in, keep the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_W-2:0], fits};
      rem_q <= fits ? 8'(trial - {1'b0, den_q}) : trial[7:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = num_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== src/sgwu_exp_rom.sv =====
// Gaussian neighbourhood factor table, exp(-t) in Q1.16, built at elaboration.
// Depends on sgwu_pkg for the table construction functions.
`timescale 1ns / 1ps

module sgwu_exp_rom import sgwu_pkg::*; #(
  parameter int EXP_TABLE_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        look_i,
  input  logic        far_i,
  input  logic [11:0] t_i,
  output logic [16:0] lam_o
);

  localparam int          IW        = $clog2(EXP_TABLE_SIZE);
  localparam logic [63:0] EXP_STEP  = (64'd16 << 32) / EXP_TABLE_SIZE;
  localparam logic [63:0] EXP_BASE  = taylor_base(EXP_STEP);

  logic [16:0]   tab [EXP_TABLE_SIZE];
  logic [IW-1:0] idx;
  logic [16:0]   lam_q;

  // Constant entries
  for (genvar k = 0; k < EXP_TABLE_SIZE; k++) begin : g_tab
    localparam logic [16:0] ENTRY = exp_entry(EXP_BASE, k);
    assign tab[k] = ENTRY;
  end

  // Scale t onto the table span
  assign idx = IW'((32'(t_i) * EXP_TABLE_SIZE) >> T_SPAN_LOG2);

  // Register the looked-up factor; zero beyond the span
  always_ff @(posedge clk_i) begin
    if (look_i) begin
      lam_q <= far_i ? 17'd0 : tab[idx];
    end
  end

  assign lam_o = lam_q;

endmodule

// ===== src/som_gaussian_weight_update.sv =====
// Top level: weight memory, configuration registers and the update sequencer.
// Depends on sgwu_pkg, sgwu_mul, sgwu_div and sgwu_exp_rom.
//
//   channel | signals                              | transfer
//   --------+--------------------------------------+-------------------------
//   in      | in_valid_i, in_ready_o, in_data_i     | valid & ready at clk edge
//   out     | out_valid_o, out_ready_i, out_data_o  | valid & ready at clk edge
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i      | write when we is high
//
// A write or read transaction goes straight to the done state; a train
// transaction first runs two 12-step divisions that place the winner and the first
// neuron on the grid, then each neuron runs 7 steps through the one shared
// multiplier and a read-modify-write of the weight memory.
// Reset clears control and loads the register defaults; weights are undefined
// until written. A waiting result holds in the output register while the next
// transaction is accepted; the sequencer stalls only at its end.
`timescale 1ns / 1ps

module som_gaussian_weight_update import sgwu_pkg::*; #(
  parameter int MAX_NEURONS    = 128,
  parameter int MAX_DIM        = 64,
  parameter int EXP_TABLE_SIZE = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sgwu_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sgwu_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int MEM_DEPTH = MAX_NEURONS * MAX_DIM;
  localparam int AW        = $clog2(MEM_DEPTH);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_WDIV  = 12'b0000_0000_0010,
    S_ODIV  = 12'b0000_0000_0100,
    S_SQR_R = 12'b0000_0000_1000,
    S_SQR_C = 12'b0000_0001_0000,
    S_SCALE = 12'b0000_0010_0000,
    S_LOOK  = 12'b0000_0100_0000,
    S_GAIN  = 12'b0000_1000_0000,
    S_APPLY = 12'b0001_0000_0000,
    S_WRITE = 12'b0010_0000_0000,
    S_DONE  = 12'b0100_0000_0000,
    S_SPARE = 12'b1000_0000_0000
  } state_e;

  // Configuration registers
  logic [15:0] learning_rate_q;
  logic [15:0] inv_two_sigma_q;
  logic [7:0]  grid_cols_q;
  logic [7:0]  neuron_count_q;
  logic [6:0]  vector_dim_q;
  logic [11:0] unit_offset_q;

  // Control
  state_e    state_q, state_d;
  logic      status_q;
  logic      is_read_q;
  logic [7:0] cnt_q;
  logic      out_valid_q;
  sgwu_out_t out_q;

  // Datapath
  sgwu_in_t    item_q;
  logic [11:0] wr_q;
  logic [7:0]  wc_q;
  logic [12:0] row_q;
  logic [7:0]  col_q;
  logic [25:0] sq_q;
  logic [26:0] d2_q;
  logic [11:0] t_q;
  logic        far_q;
  logic [16:0] mag_q;
  logic        neg_q;
  logic [32:0] a_q;
  logic [18:0] delta_q;

  // Weight memory
  logic [15:0]   mem [MEM_DEPTH];
  logic [15:0]   mem_rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr, in_addr, train_addr;
  logic [15:0]   mem_wdata;

  // Misc combinational
  logic        accept, load_out, last_neuron;
  logic [7:0]  cols_eff, ncount;
  logic [6:0]  dim;
  logic        nrn_bad, elem_bad, train_ok;
  logic [12:0] dr;
  logic [7:0]  dc;
  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] prod;
  logic [50:0] rounded;
  logic        div_start;
  logic [11:0] div_dividend;
  div_res_t    div_res;
  logic [16:0] lam;
  logic signed [16:0] diff;
  logic signed [20:0] w_ext, delta_ext, upd;
  logic [15:0] upd_sat;

  // Effective limits
  assign cols_eff = (grid_cols_q == 8'd0) ? 8'd1 : grid_cols_q;
  assign ncount   = (32'(neuron_count_q) > MAX_NEURONS) ? 8'(MAX_NEURONS) : neuron_count_q;
  assign dim      = (32'(vector_dim_q) > MAX_DIM) ? 7'(MAX_DIM) : vector_dim_q;
  assign nrn_bad  = {1'b0, in_data_i.neuron} >= ncount;
  assign elem_bad = {1'b0, in_data_i.element} >= dim;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign train_ok   = accept && (in_data_i.cmd == CMD_TRAIN) && !elem_bad;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign last_neuron = ({1'b0, cnt_q} + 9'd1) == {1'b0, ncount};

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learning_rate_q <= 16'd6554;
      inv_two_sigma_q <= 16'd128;
      grid_cols_q     <= 8'd10;
      neuron_count_q  <= 8'd100;
      vector_dim_q    <= 7'd64;
      unit_offset_q   <= 12'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEARNING_RATE: learning_rate_q <= cfg_wdata_i;
        CFG_INV_TWO_SIGMA: inv_two_sigma_q <= cfg_wdata_i;
        CFG_GRID_COLS:     grid_cols_q     <= cfg_wdata_i[7:0];
        CFG_NEURON_COUNT:  neuron_count_q  <= cfg_wdata_i[7:0];
        CFG_VECTOR_DIM:    vector_dim_q    <= cfg_wdata_i[6:0];
        CFG_UNIT_OFFSET:   unit_offset_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // Memory addressing and port control
  assign in_addr    = AW'(32'(in_data_i.neuron) * MAX_DIM + 32'(in_data_i.element));
  assign train_addr = AW'(32'(cnt_q) * MAX_DIM + 32'(item_q.element));

  assign mem_re    = (accept && (in_data_i.cmd == CMD_READ) && !nrn_bad && !elem_bad)
                     || (state_q == S_SQR_R);
  assign mem_raddr = (state_q == S_SQR_R) ? train_addr : in_addr;
  assign mem_we    = (accept && (in_data_i.cmd == CMD_WRITE) && !nrn_bad && !elem_bad)
                     || (state_q == S_WRITE);
  assign mem_waddr = (state_q == S_WRITE) ? train_addr : in_addr;
  assign mem_wdata = (state_q == S_WRITE) ? upd_sat : in_data_i.value;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_raddr];
    end
  end

  // Shared grid divider: winner first, then the slice offset
  assign div_start    = train_ok || ((state_q == S_WDIV) && div_res.done);
  assign div_dividend = (state_q == S_IDLE) ? in_data_i.winner : unit_offset_q;

  sgwu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cols_eff),
    .res_o      (div_res)
  );

  // Grid distances
  assign dr = (row_q > {1'b0, wr_q}) ? (row_q - {1'b0, wr_q}) : ({1'b0, wr_q} - row_q);
  assign dc = (col_q > wc_q) ? (col_q - wc_q) : (wc_q - col_q);

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQR_R: begin
        mul_a = 33'(dr);
        mul_b = 17'(dr);
      end
      S_SQR_C: begin
        mul_a = 33'(dc);
        mul_b = 17'(dc);
      end
      S_SCALE: begin
        mul_a = 33'(d2_q[11:0]);
        mul_b = 17'(inv_two_sigma_q);
      end
      S_GAIN: begin
        mul_a = 33'(learning_rate_q);
        mul_b = lam;
      end
      S_APPLY: begin
        mul_a = a_q;
        mul_b = mag_q;
      end
      default: ;
    endcase
  end

  sgwu_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  sgwu_exp_rom #(
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_rom (
    .clk_i  (clk_i),
    .look_i (state_q == S_LOOK),
    .far_i  (far_q),
    .t_i    (t_q),
    .lam_o  (lam)
  );

  // Difference, rounding and saturation of the update
  assign diff      = $signed({item_q.value[15], item_q.value})
                     - $signed({mem_rd_q[15], mem_rd_q});
  assign rounded   = 51'(prod) + 51'h0_8000_0000;
  assign w_ext     = $signed({{5{mem_rd_q[15]}}, mem_rd_q});
  assign delta_ext = $signed({2'b00, delta_q});
  assign upd       = neg_q ? (w_ext - delta_ext) : (w_ext + delta_ext);

  always_comb begin
    if (upd > 21'sd32767) begin
      upd_sat = 16'h7fff;
    end else if (upd < -21'sd32768) begin
      upd_sat = 16'h8000;
    end else begin
      upd_sat = upd[15:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = train_ok ? S_WDIV : S_DONE;
        end
      end
      S_WDIV: begin
        if (div_res.done) state_d = S_ODIV;
      end
      S_ODIV: begin
        if (div_res.done) state_d = (ncount == 8'd0) ? S_DONE : S_SQR_R;
      end
      S_SQR_R: state_d = S_SQR_C;
      S_SQR_C: state_d = S_SCALE;
      S_SCALE: state_d = S_LOOK;
      S_LOOK:  state_d = S_GAIN;
      S_GAIN:  state_d = S_APPLY;
      S_APPLY: state_d = S_WRITE;
      S_WRITE: state_d = last_neuron ? S_DONE : S_SQR_R;
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= 1'b0;
      is_read_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        is_read_q <= (in_data_i.cmd == CMD_READ);
        case (in_data_i.cmd)
          CMD_WRITE, CMD_READ: status_q <= nrn_bad || elem_bad;
          CMD_TRAIN:           status_q <= elem_bad;
          default:             status_q <= 1'b1;
        endcase
      end
      if ((state_q == S_ODIV) && div_res.done) begin
        cnt_q <= '0;
      end else if (state_q == S_WRITE) begin
        cnt_q <= cnt_q + 8'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if ((state_q == S_WDIV) && div_res.done) begin
      wr_q <= div_res.quot;
      wc_q <= div_res.rem;
    end
    if ((state_q == S_ODIV) && div_res.done) begin
      row_q <= {1'b0, div_res.quot};
      col_q <= div_res.rem;
    end else if (state_q == S_WRITE) begin
      // Step to the next neuron on the grid
      if (col_q == cols_eff - 8'd1) begin
        col_q <= '0;
        row_q <= row_q + 13'd1;
      end else begin
        col_q <= col_q + 8'd1;
      end
    end
    case (state_q)
      S_SQR_R: sq_q <= prod[25:0];
      S_SQR_C: d2_q <= 27'(sq_q) + 27'(prod[15:0]);
      S_SCALE: begin
        t_q   <= prod[11:0];
        far_q <= ((|d2_q[26:12]) && (inv_two_sigma_q != 16'd0)) || (|prod[27:12]);
        neg_q <= diff[16];
        mag_q <= diff[16] ? 17'(-diff) : 17'(diff);
      end
      S_GAIN:  a_q     <= prod[32:0];
      S_APPLY: delta_q <= rounded[50:32];
      default: ;
    endcase
    if (load_out) begin
      out_q.read_value <= (is_read_q && !status_q) ? mem_rd_q : 16'd0;
      out_q.status     <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
